[sv/b64e_pkg.sv]
// Package for the Base64 encoder: payload types, character entries and constants.
package b64e_pkg;

  localparam int unsigned AlphaWords = 8;
  localparam int unsigned CharsPerWord = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned MaxChars = 4;
  localparam int unsigned CntW = 3;
  localparam logic [7:0] PadChar = 8'd61;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  // Alphabet table, indexed [word][byte]
  typedef logic [AlphaWords-1:0][CharsPerWord-1:0][7:0] alphabet_t;

  // One pending output character before alphabet lookup
  typedef struct packed {
    logic       pad;
    logic [5:0] sextet;
    logic       last;
  } char_ent_t;

  // Head of the pending character buffer
  typedef struct packed {
    logic      valid;
    char_ent_t ent;
  } head_t;

  // Bytes seen so far in the current three-byte group
  typedef enum logic [1:0] {
    PhZero = 2'd0,
    PhOne  = 2'd1,
    PhTwo  = 2'd2
  } phase_e;

endpackage

[sv/b64e_alphabet.sv]
// Alphabet configuration registers for the Base64 encoder.
module b64e_alphabet import b64e_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output alphabet_t           alpha_o
);

  localparam int unsigned SelW = $clog2(AlphaWords);

  alphabet_t words_q, words_d;
  logic      hit;

  assign cfg_ready_o = 1'b1;
  // indexes past the last word are dropped
  assign hit = (cfg_index_i[CfgIdxW-1:SelW] == '0);

  // register write
  always_comb begin
    words_d = words_q;
    if (cfg_valid_i && hit) begin
      words_d[cfg_index_i[SelW-1:0]] = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= '0;
    end else begin
      words_q <= words_d;
    end
  end

  assign alpha_o = words_q;

endmodule

[sv/b64e_split.sv]
// Byte intake: group phase tracking and the buffer of pending sextet characters.
module b64e_split import b64e_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output head_t    head_o,
  input  logic     pop_i
);

  phase_e         phase_q, phase_d;
  logic [3:0]     left_q, left_d;
  logic [CntW-1:0] cnt_q, cnt_d, n_new;
  char_ent_t      ent_q [MaxChars];
  char_ent_t      ent_d [MaxChars];
  char_ent_t      new_e [MaxChars];
  logic           accept;
  logic [7:0]     b;
  logic           lst;

  assign b      = in_data_i.data_byte;
  assign lst    = in_data_i.last_byte;
  assign in_ready_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && pop_i);
  assign accept = in_valid_i && in_ready_o;

  // phase and leftover bits for the next byte
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    if (accept) begin
      if (lst) begin
        phase_d = PhZero;
        left_d  = '0;
      end else begin
        unique case (phase_q)
          PhOne: begin
            phase_d = PhTwo;
            left_d  = b[3:0];
          end
          PhTwo: begin
            phase_d = PhZero;
            left_d  = '0;
          end
          default: begin
            phase_d = PhOne;
            left_d  = {2'b00, b[1:0]};
          end
        endcase
      end
    end
  end

  // characters caused by the incoming byte
  always_comb begin
    for (int i = 0; i < MaxChars; i++) begin
      new_e[i] = '0;
    end
    n_new = CntW'(1);
    unique case (phase_q)
      PhOne: begin
        new_e[0].sextet = {left_q[1:0], b[7:4]};
        if (lst) begin
          new_e[1].sextet = {b[3:0], 2'b00};
          new_e[2].pad    = 1'b1;
          new_e[2].last   = 1'b1;
          n_new           = CntW'(3);
        end
      end
      PhTwo: begin
        new_e[0].sextet = {left_q, b[7:6]};
        new_e[1].sextet = b[5:0];
        new_e[1].last   = lst;
        n_new           = CntW'(2);
      end
      default: begin
        // unused phase behaves as the group start, leftover dropped
        new_e[0].sextet = b[7:2];
        if (lst) begin
          new_e[1].sextet = {b[1:0], 4'b0000};
          new_e[2].pad    = 1'b1;
          new_e[3].pad    = 1'b1;
          new_e[3].last   = 1'b1;
          n_new           = CntW'(4);
        end
      end
    endcase
  end

  // buffer load or shift toward the head
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxChars; i++) begin
      ent_d[i] = ent_q[i];
    end
    if (accept) begin
      cnt_d = n_new;
      for (int i = 0; i < MaxChars; i++) begin
        ent_d[i] = new_e[i];
      end
    end else if (pop_i && (cnt_q != '0)) begin
      cnt_d = cnt_q - CntW'(1);
      for (int i = 0; i < MaxChars - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhZero;
      left_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxChars; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.ent   = ent_q[0];

  // buffer never holds more than one byte's characters
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxChars))
    else $error("pending character count out of range");

  // a final byte always restarts the group
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && lst) |=> (phase_q == PhZero) && (left_q == '0))
    else $error("group state not cleared after final byte");

  // stalled intake only while characters are pending
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (cnt_q != '0))
    else $error("intake stalled with empty buffer");

endmodule

[sv/b64e_emit.sv]
// Character emitter: alphabet lookup into the output register.
module b64e_emit import b64e_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  alphabet_t alpha_i,
  input  head_t     head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      valid_q, valid_d;
  out_item_t data_q, data_d;
  logic      take;

  assign take  = !valid_q || out_ready_i;
  assign pop_o = take && head_i.valid;

  // lookup of the head character
  always_comb begin
    data_d = data_q;
    valid_d = valid_q && !out_ready_i;
    if (pop_o) begin
      valid_d          = 1'b1;
      data_d.last_char = head_i.ent.last;
      if (head_i.ent.pad) begin
        data_d.out_char = PadChar;
      end else begin
        data_d.out_char = alpha_i[head_i.ent.sextet[5:3]][head_i.ent.sextet[2:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[sv/base64_encoder_custom_alphabet.sv]
// First character of a byte passes through the pending buffer, then the output register.
// Throughput: one character per cycle while out_ready_i is not held low; a byte takes 1 to 4
// characters, and intake holds until the pending buffer, which holds one byte's characters,
// has only its last character left and that character is popped.
// Reset clears the alphabet to zero, the group phase, the pending buffer and the output valid.
// Top level of the Base64 encoder with configurable alphabet.
module base64_encoder_custom_alphabet import b64e_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  alphabet_t alpha;
  head_t     head;
  logic      pop;

  b64e_alphabet u_alphabet (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .alpha_o     (alpha)
  );

  b64e_split u_split (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  b64e_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .alpha_i     (alpha),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
